@@ rtl/sync_checksum_frame_receiver_unit_assert.svh @@
// assertion macros for the sync checksum frame receiver
`ifndef SYNC_CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SYNC_CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check a property on every rising clock edge outside of reset
`define SCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check an implication on every rising clock edge outside of reset
`define SCFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SCFR_ASSERT(lbl, prop, msg)
`define SCFR_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/scfr_pkg.sv @@
// types and constants shared by the frame receiver modules
`timescale 1ns / 1ps
package scfr_pkg;

  localparam int unsigned WIN_DEPTH = 7;
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned FILL_W    = 3;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

  localparam logic [7:0] SYNC_FIRST  = 8'hEB;
  localparam logic [7:0] SYNC_SECOND = 8'h90;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // first member sits in the highest bits, so function_code lands in bits 7:0
  typedef struct packed {
    logic [15:0] speed_command;
    logic [7:0]  data_byte_three;
    logic [7:0]  data_byte_two;
    logic [7:0]  data_byte_one;
    logic [7:0]  data_byte_zero;
    logic [7:0]  function_code;
  } frame_t;

endpackage

@@ rtl/scfr_cell.sv @@
// one byte cell of the receive window shift chain
`timescale 1ns / 1ps
module scfr_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

@@ rtl/scfr_check.sv @@
// sync word and additive checksum test over the window plus the new byte
`timescale 1ns / 1ps
module scfr_check (
  input  scfr_pkg::win_t   window_i,
  input  logic [7:0]       byte_i,
  output logic             hit_o,
  output scfr_pkg::frame_t frame_o
);
  import scfr_pkg::*;

  logic [FRAME_LEN-1:0][7:0] fr;
  logic [7:0]                sum;

  always_comb begin
    fr                = '0;
    fr[WIN_DEPTH-1:0] = window_i;
    fr[FRAME_LEN-1]   = byte_i;
  end

  // checksum covers frame bytes 2 through 7, modulo 256
  always_comb begin
    sum = 8'h00;
    for (int i = 2; i < FRAME_LEN; i++) begin
      sum = sum + fr[i];
    end
  end

  assign hit_o = (fr[0] == SYNC_FIRST) && (fr[1] == SYNC_SECOND) && (sum == 8'h00);

  always_comb begin
    frame_o.function_code   = fr[2];
    frame_o.data_byte_zero  = fr[3];
    frame_o.data_byte_one   = fr[4];
    frame_o.data_byte_two   = fr[5];
    frame_o.data_byte_three = fr[6];
    frame_o.speed_command   = {fr[4], fr[5]};
  end

endmodule

@@ rtl/sync_checksum_frame_receiver_unit.sv @@
// sync word frame receiver: byte input stream in, decoded frame stream out
//
// s_axis takes one received byte per item in tdata[7:0]. every accepted byte
// moves down a chain of seven byte cells; once seven bytes are held, each new
// byte completes an eight byte candidate (0xEB 0x90, then six bytes whose sum
// is zero modulo 256). a hit gives one item on m_axis and empties the window,
// a miss simply drops the oldest byte.
// throughput is one byte per cycle while s_axis_tready is high, set by the single
// shift of the cell chain and the six byte sum done in the same cycle.
// a completed frame is registered: it goes to the output register, or to the skid
// register while the output register holds a frame that m_axis is not taking.
// m_axis carries the result from an output register backed by one skid
// register, so s_axis keeps taking bytes while a frame waits; s_axis_tready
// drops only while both hold a frame.
// reset empties the window and both output registers; the first frame can
// complete on the eighth byte after reset.
`timescale 1ns / 1ps
module sync_checksum_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] received_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [7:0] function_code, [15:8] data_byte_zero,
                                      // [23:16] data_byte_one, [31:24] data_byte_two,
                                      // [39:32] data_byte_three, [55:40] speed_command
);
  import scfr_pkg::*;

  `include "sync_checksum_frame_receiver_unit_assert.svh"

  win_t              win;
  logic              in_acc;
  logic              out_taken;
  logic              hit;
  logic              full;
  logic              new_res;
  frame_t            frame;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  frame_t            out_q, out_d;
  frame_t            skid_q, skid_d;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_taken     = out_valid_q && m_axis_tready;
  assign full          = (fill_q == FILL_FULL);
  assign new_res       = in_acc && full && hit;

  // window chain, cell 0 oldest, new bytes enter at the top cell
  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
    if (g == WIN_DEPTH - 1) begin : g_top
      scfr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .byte_i  (s_axis_tdata),
        .byte_o  (win[g])
      );
    end else begin : g_mid
      scfr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .byte_i  (win[g+1]),
        .byte_o  (win[g])
      );
    end
  end

  scfr_check u_check (
    .window_i (win),
    .byte_i   (s_axis_tdata),
    .hit_o    (hit),
    .frame_o  (frame)
  );

  always_comb begin
    fill_d = fill_q;
    if (in_acc) begin
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end else if (hit) begin
        fill_d = '0;
      end
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_taken) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (new_res) begin
        out_d = frame;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (new_res) begin
      if (out_valid_q) begin
        skid_d       = frame;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = frame;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `SCFR_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `SCFR_ASSERT(a_res_shows, new_res |=> out_valid_q, "frame hit did not reach the output")
  `SCFR_ASSERT(a_fill_step, (in_acc && !full) |=> (fill_q == $past(fill_q) + 3'd1), "fill stuck")

endmodule

@@ verif/scfr_frame_checker.sv @@
// frame checker: watches both streams, predicts decoded frames and compares
`timescale 1ns / 1ps
module scfr_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] received_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // [7:0] function_code, [15:8] data_byte_zero,
                                      // [23:16] data_byte_one, [31:24] data_byte_two,
                                      // [39:32] data_byte_three, [55:40] speed_command
  output int          fail_count_o,
  output int          pending_o
);
  import scfr_pkg::*;

  logic [7:0]  held [WIN_DEPTH];
  int unsigned held_cnt;
  frame_t      frames_due [$];
  int          errors = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // slide the byte window and queue a frame when sync and checksum line up
  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0] cand [FRAME_LEN];
    logic [7:0] sum;
    frame_t     fr;
    if (held_cnt < WIN_DEPTH) begin
      held[held_cnt] = b;
      held_cnt++;
    end else begin
      for (int i = 0; i < WIN_DEPTH; i++) cand[i] = held[i];
      cand[FRAME_LEN-1] = b;
      sum = 8'h00;
      for (int i = 2; i < FRAME_LEN; i++) sum += cand[i];
      if (cand[0] == SYNC_FIRST && cand[1] == SYNC_SECOND && sum == 8'h00) begin
        fr.function_code   = cand[2];
        fr.data_byte_zero  = cand[3];
        fr.data_byte_one   = cand[4];
        fr.data_byte_two   = cand[5];
        fr.data_byte_three = cand[6];
        fr.speed_command   = {cand[4], cand[5]};
        frames_due.push_back(fr);
        held_cnt = 0;
      end else begin
        for (int i = 0; i + 1 < WIN_DEPTH; i++) held[i] = held[i+1];
        held[WIN_DEPTH-1] = b;
      end
    end
  endtask

  task automatic compare_frame(input frame_t got);
    frame_t want;
    if (frames_due.size() == 0) begin
      report_mismatch("unexpected frame, function_code", 16'(got.function_code), 16'h0);
    end else begin
      want = frames_due.pop_front();
      if (got.function_code !== want.function_code)
        report_mismatch("function_code", 16'(got.function_code),
                        16'(want.function_code));
      if (got.data_byte_zero !== want.data_byte_zero)
        report_mismatch("data_byte_zero", 16'(got.data_byte_zero),
                        16'(want.data_byte_zero));
      if (got.data_byte_one !== want.data_byte_one)
        report_mismatch("data_byte_one", 16'(got.data_byte_one),
                        16'(want.data_byte_one));
      if (got.data_byte_two !== want.data_byte_two)
        report_mismatch("data_byte_two", 16'(got.data_byte_two),
                        16'(want.data_byte_two));
      if (got.data_byte_three !== want.data_byte_three)
        report_mismatch("data_byte_three", 16'(got.data_byte_three),
                        16'(want.data_byte_three));
      if (got.speed_command !== want.speed_command)
        report_mismatch("speed_command", got.speed_command, want.speed_command);
    end
  endtask

  // a frame leaves only from a register after its last byte, so compare before absorbing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 0;
      frames_due.delete();
      for (int i = 0; i < WIN_DEPTH; i++) held[i] = 8'h00;
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_frame(frame_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata);
    end
    pending_o    = frames_due.size();
    fail_count_o = errors;
  end

endmodule

@@ verif/tb_top.sv @@
// testbench top: byte stimulus, output backpressure and final verdict
`timescale 1ns / 1ps
module tb_top;
  import scfr_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int ITEM_TARGET  = 1600;
  localparam int PHASE_LEN    = 540;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  int fail_count;
  int pending;
  int snd_idle_pct = 12;
  int rcv_idle_pct = 65;
  int bytes_sent   = 0;

  sync_checksum_frame_receiver_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scfr_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sync_checksum_frame_receiver_unit verification failed");
    $finish;
  end

  function automatic logic [7:0] checksum_for(input logic [7:0] f, input logic [7:0] d0,
                                              input logic [7:0] d1, input logic [7:0] d2,
                                              input logic [7:0] d3);
    return 8'(8'h00 - (f + d0 + d1 + d2 + d3));
  endfunction

  // mostly random, with the byte extremes showing up often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // tready is stable by the falling edge, so sample it there
  task automatic push_byte(input logic [7:0] b);
    logic rdy;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    bytes_sent++;
  endtask

  task automatic push_frame(input logic [7:0] f, input logic [7:0] d0, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [7:0] d3, input logic [7:0] cs);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(f);
    push_byte(d0);
    push_byte(d1);
    push_byte(d2);
    push_byte(d3);
    push_byte(cs);
  endtask

  // hold the byte stream until every predicted frame has come out
  task automatic wait_frames_out();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] fb [FRAME_LEN];
    int         kind;
    int         cnt;
    int         idx;
    int         phase;
    phase = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero frame, all-ones payload, then sync with a bad checksum
    push_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               checksum_for(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_frame(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    while (bytes_sent < ITEM_TARGET) begin
      if (phase == 0 && bytes_sent >= PHASE_LEN) begin
        wait_frames_out();
        snd_idle_pct = 65;
        rcv_idle_pct = 12;
        phase = 1;
      end else if (phase == 1 && bytes_sent >= 2 * PHASE_LEN) begin
        wait_frames_out();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        phase = 2;
      end
      fb[0] = SYNC_FIRST;
      fb[1] = SYNC_SECOND;
      for (int i = 2; i < FRAME_LEN - 1; i++) fb[i] = pick_byte();
      fb[FRAME_LEN-1] = checksum_for(fb[2], fb[3], fb[4], fb[5], fb[6]);
      kind = $urandom_range(99);
      if (kind < 70) begin
        for (int i = 0; i < FRAME_LEN; i++) push_byte(fb[i]);
      end else if (kind < 82) begin
        // one byte of the frame damaged
        idx = $urandom_range(FRAME_LEN - 1);
        fb[idx] = fb[idx] ^ 8'($urandom_range(255, 1));
        for (int i = 0; i < FRAME_LEN; i++) push_byte(fb[i]);
      end else if (kind < 92) begin
        cnt = $urandom_range(6, 1);
        for (int i = 0; i < cnt; i++) push_byte(8'($urandom_range(255)));
      end else begin
        // frame cut short
        cnt = $urandom_range(FRAME_LEN - 1, 1);
        for (int i = 0; i < cnt; i++) push_byte(fb[i]);
      end
    end

    wait_frames_out();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sync_checksum_frame_receiver_unit verification clean");
    end else begin
      $display("sync_checksum_frame_receiver_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sync_checksum_frame_receiver_unit.f @@
+incdir+rtl
rtl/scfr_pkg.sv
rtl/scfr_cell.sv
rtl/scfr_check.sv
rtl/sync_checksum_frame_receiver_unit.sv
verif/scfr_frame_checker.sv
verif/tb_top.sv
